### hdl/assert_macros.svh
// assertion macros shared by the pwm serializer channel rtl
// each macro expects clk_i and rst_ni in the scope of its use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/psc_pkg.sv
// shared types and constants of the pwm serializer channel
// no dependencies
package psc_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned RANGE_W        = 32;
  localparam int unsigned ACC_W          = 33;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 2'd3;

  // mode codes, bit 1 selects serial operation
  localparam logic [1:0] MODE_SPREAD = 2'd0;
  localparam logic [1:0] MODE_MARK   = 2'd1;
  localparam logic [1:0] MODE_SERIAL = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic               enable;
    logic [RANGE_W-1:0] range;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] counter;
    logic [ACC_W-1:0]   acc;
    logic               pin;
  } state_t;

endpackage

### hdl/psc_intf.sv
// valid/ready channel interfaces of the pwm serializer channel
// depends on psc_pkg
interface psc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [psc_pkg::CFG_IDX_W-1:0]      reg_index;
  logic [psc_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

interface psc_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, tick, input ready);
  modport sink   (input valid, tick, output ready);
endinterface

interface psc_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic period_end;
  modport source (output valid, pin_level, period_end, input ready);
  modport sink   (input valid, pin_level, period_end, output ready);
endinterface

### hdl/psc_cfg_regs.sv
// configuration register bank of the pwm serializer channel
// depends on psc_pkg and psc_intf
module psc_cfg_regs #(
  parameter int unsigned DATA_WIDTH = psc_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psc_cfg_if.sink               cfg_ch_i,
  output psc_pkg::cfg_t         cfg_o,
  output logic [DATA_WIDTH-1:0] duty_o
);
  import psc_pkg::*;

  cfg_t                  cfg_q;
  logic [DATA_WIDTH-1:0] duty_q;

  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      duty_q <= '0;
    end else if (cfg_ch_i.valid) begin
      unique case (cfg_ch_i.reg_index)
        REG_MODE:   cfg_q.mode   <= cfg_ch_i.wdata[1:0];
        REG_ENABLE: cfg_q.enable <= cfg_ch_i.wdata[0];
        REG_DUTY:   duty_q       <= cfg_ch_i.wdata[DATA_WIDTH-1:0];
        REG_RANGE:  cfg_q.range  <= cfg_ch_i.wdata[RANGE_W-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  assign cfg_o  = cfg_q;
  assign duty_o = duty_q;

endmodule

### hdl/psc_step.sv
// next-state and pin level of one pwm tick
// depends on psc_pkg
module psc_step #(
  parameter int unsigned DATA_WIDTH = psc_pkg::DATA_WIDTH_DEF
) (
  input  psc_pkg::cfg_t         cfg_i,
  input  logic [DATA_WIDTH-1:0] duty_i,
  input  psc_pkg::state_t       state_i,
  input  logic                  tick_i,
  output psc_pkg::state_t       state_o,
  output logic                  level_o,
  output logic                  last_o
);
  import psc_pkg::*;

  localparam int unsigned IDX_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam int unsigned SUM_W = ACC_W + 1;

  logic               run;
  logic [RANGE_W-1:0] duty_ext;
  logic               sat;
  logic [IDX_W-1:0]   bit_pos;
  logic               ser_bit;
  logic [RANGE_W-1:0] add_val;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_sub;
  logic [SUM_W-1:0]   range_ext;
  logic               sum_ge;
  logic [ACC_W-1:0]   acc_next;
  logic               level;
  logic               last;

  assign run       = cfg_i.enable && (cfg_i.range != '0);
  assign duty_ext  = RANGE_W'(duty_i);
  assign sat       = duty_ext >= cfg_i.range;
  assign range_ext = SUM_W'(cfg_i.range);

  // serial bit, msb first, zero past the data width
  assign bit_pos = IDX_W'(DATA_WIDTH - 1) - state_i.counter[IDX_W-1:0];
  assign ser_bit = (state_i.counter < RANGE_W'(DATA_WIDTH)) ? duty_i[bit_pos] : 1'b0;

  // sigma-delta accumulate, duty clamped at the range
  assign add_val = sat ? cfg_i.range : duty_ext;
  assign sum     = SUM_W'(state_i.acc) + SUM_W'(add_val);
  assign sum_ge  = sum >= range_ext;
  assign sum_sub = sum_ge ? (sum - range_ext) : sum;

  always_comb begin
    acc_next = state_i.acc;
    level    = 1'b0;
    case (cfg_i.mode) inside
      MODE_SERIAL, MODE_RSVD: level = ser_bit;
      MODE_MARK:              level = sat || (state_i.counter < duty_ext);
      default: begin
        level    = sum_ge;
        // a lowered range can leave the sum above it
        acc_next = (sum_sub >= range_ext) ? '0 : ACC_W'(sum_sub);
      end
    endcase
  end

  assign last = state_i.counter >= (cfg_i.range - RANGE_W'(1));

  always_comb begin
    state_o = state_i;
    level_o = state_i.pin;
    last_o  = 1'b0;
    if (!run) begin
      state_o = '0;
      level_o = 1'b0;
    end else if (tick_i) begin
      state_o.counter = last ? '0 : (state_i.counter + RANGE_W'(1));
      state_o.acc     = acc_next;
      state_o.pin     = level;
      level_o         = level;
      last_o          = last;
    end
  end

endmodule

### hdl/pwm_serializer_channel_unit.sv
// pwm_serializer_channel_unit: one pwm output channel (spread, mark-space, serializer)
// depends on psc_pkg, psc_intf, psc_cfg_regs, psc_step and assert_macros.svh
//
// channels: in_ch_i carries one tick per transfer (1 advances the pwm clock,
// 0 repeats the current pin level); every input transfer produces exactly one
// result transfer on out_ch_o with pin_level and period_end. cfg_ch_i writes
// mode_select (0), channel_enable (1), duty_data (2) and period_range (3);
// it is always ready and must only be used while the channel is idle.
// an accepted item is held in the input register and moves into the result
// register, from which out_ch_o offers it. throughput: one item per cycle
// while out_ch_o is ready, as the period counter and accumulator update
// combinationally between the two registers.
// reset: config, period counter, accumulator and pin are cleared, both
// pipeline registers are emptied; the pin reads low until enabled with a nonzero range.
// stall: while out_ch_o is not ready the result register holds; one more
// item still lands in the input register, after which in_ch_i deasserts
// ready until the result is taken. no item is dropped or repeated.
`include "assert_macros.svh"

module pwm_serializer_channel_unit #(
  parameter int unsigned DATA_WIDTH = psc_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psc_cfg_if.sink   cfg_ch_i,
  psc_in_if.sink    in_ch_i,
  psc_out_if.source out_ch_o
);
  import psc_pkg::*;

  cfg_t                  cfg;
  logic [DATA_WIDTH-1:0] duty;

  // input register
  logic s1_valid_q;
  logic s1_tick_q;
  logic s1_adv;

  // channel state
  state_t state_q;
  state_t state_d;
  logic   step_level;
  logic   step_last;

  // result register
  logic out_valid_q;
  logic out_pin_q;
  logic out_end_q;
  logic out_free;

  psc_cfg_regs #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_ch_i (cfg_ch_i),
    .cfg_o    (cfg),
    .duty_o   (duty)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free       = !out_valid_q || out_ch_o.ready;
  assign s1_adv         = s1_valid_q && out_free;
  assign in_ch_i.ready  = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      s1_tick_q <= in_ch_i.tick;
    end
  end

  psc_step #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_step (
    .cfg_i   (cfg),
    .duty_i  (duty),
    .state_i (state_q),
    .tick_i  (s1_tick_q),
    .state_o (state_d),
    .level_o (step_level),
    .last_o  (step_last)
  );

  // state moves only when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pin_q <= step_level;
      out_end_q <= step_last;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.pin_level  = out_pin_q;
  assign out_ch_o.period_end = out_end_q;

  // a disabled channel leaves cleared state behind
  `ASSERT_NEXT(a_disable_clears, s1_adv && !cfg.enable, (state_q == '0), "disabled tick left state")
  // end of period restarts the counter
  `ASSERT_NEXT(a_end_restarts, s1_adv && step_last, (state_q.counter == '0), "counter not restarted")
  // a held item stays in the input register
  `ASSERT_NEXT(a_item_held, s1_valid_q && !s1_adv, s1_valid_q, "pending item lost")

endmodule
